// ===== rtl/mps_pkg.sv =====
// Shared types, constants and the lane product schedule for the matrix pattern scanner.
// No dependencies; imported by every module of the block but mps_ram.
`default_nettype none

package mps_pkg;

    localparam int FRACTION_BITS_DEF = 26;
    localparam int IDX_W      = 44;
    localparam int CNT_W      = 13;
    localparam int WIN_DEPTH  = 8;
    localparam int CHUNK_W    = 128;
    localparam int NUM_ELEMS  = 16;
    localparam int VAL_W      = 64;
    localparam int NUM_STEPS  = 45;
    localparam int STEP_W     = 6;
    localparam int FILL_W     = 4;

    localparam logic [CNT_W-1:0] MAX_CAND_RST = CNT_W'(512);

    // Classification of one matrix
    typedef enum logic [1:0] {
        K_NONE,
        K_PROJ,
        K_VIEW
    } kind_t;

    // Result registers of the product schedule
    typedef enum logic [3:0] {
        R_RN0, R_RN1, R_RN2,
        R_CN0, R_CN1, R_CN2,
        R_RD01, R_RD12, R_RD02,
        R_CD01, R_CD12, R_CD02,
        R_C0, R_C1, R_C2,
        R_DET
    } res_sel_t;

    // One multiply-accumulate step: acc += (neg ? -1 : 1) * (A * B)
    typedef struct packed {
        logic [3:0] a;      // element index of operand A
        logic       b_res;  // operand B is a result register (cofactor)
        logic [3:0] b;      // element index or result register of operand B
        logic       neg;    // subtract the product
        logic       last;   // store the sum into dst and restart
        res_sel_t   dst;
    } step_t;

    // Lane status toward the top level
    typedef struct packed {
        logic  done;
        kind_t kind;
    } lane_status_t;

    // Request from the top level to the merge stage
    typedef struct packed {
        logic             start;
        logic [IDX_W-1:0] idx;
        kind_t            kind_d;
        kind_t            kind_s;
    } merge_req_t;

    function automatic step_t mk(input int a, input int b, input logic b_res,
                                 input logic neg, input logic last, input res_sel_t dst);
        step_t s;
        s.a     = 4'(a);
        s.b     = 4'(b);
        s.b_res = b_res;
        s.neg   = neg;
        s.last  = last;
        s.dst   = dst;
        return s;
    endfunction

    // Fixed schedule: norms, dots, cofactors, determinant
    function automatic step_t step_rom(input logic [STEP_W-1:0] i);
        step_t s;
        case (i)
            6'd0:  s = mk(0, 0, 1'b0, 1'b0, 1'b0, R_RN0);
            6'd1:  s = mk(1, 1, 1'b0, 1'b0, 1'b0, R_RN0);
            6'd2:  s = mk(2, 2, 1'b0, 1'b0, 1'b1, R_RN0);
            6'd3:  s = mk(4, 4, 1'b0, 1'b0, 1'b0, R_RN1);
            6'd4:  s = mk(5, 5, 1'b0, 1'b0, 1'b0, R_RN1);
            6'd5:  s = mk(6, 6, 1'b0, 1'b0, 1'b1, R_RN1);
            6'd6:  s = mk(8, 8, 1'b0, 1'b0, 1'b0, R_RN2);
            6'd7:  s = mk(9, 9, 1'b0, 1'b0, 1'b0, R_RN2);
            6'd8:  s = mk(10, 10, 1'b0, 1'b0, 1'b1, R_RN2);
            6'd9:  s = mk(0, 0, 1'b0, 1'b0, 1'b0, R_CN0);
            6'd10: s = mk(4, 4, 1'b0, 1'b0, 1'b0, R_CN0);
            6'd11: s = mk(8, 8, 1'b0, 1'b0, 1'b1, R_CN0);
            6'd12: s = mk(1, 1, 1'b0, 1'b0, 1'b0, R_CN1);
            6'd13: s = mk(5, 5, 1'b0, 1'b0, 1'b0, R_CN1);
            6'd14: s = mk(9, 9, 1'b0, 1'b0, 1'b1, R_CN1);
            6'd15: s = mk(2, 2, 1'b0, 1'b0, 1'b0, R_CN2);
            6'd16: s = mk(6, 6, 1'b0, 1'b0, 1'b0, R_CN2);
            6'd17: s = mk(10, 10, 1'b0, 1'b0, 1'b1, R_CN2);
            6'd18: s = mk(0, 4, 1'b0, 1'b0, 1'b0, R_RD01);
            6'd19: s = mk(1, 5, 1'b0, 1'b0, 1'b0, R_RD01);
            6'd20: s = mk(2, 6, 1'b0, 1'b0, 1'b1, R_RD01);
            6'd21: s = mk(4, 8, 1'b0, 1'b0, 1'b0, R_RD12);
            6'd22: s = mk(5, 9, 1'b0, 1'b0, 1'b0, R_RD12);
            6'd23: s = mk(6, 10, 1'b0, 1'b0, 1'b1, R_RD12);
            6'd24: s = mk(0, 8, 1'b0, 1'b0, 1'b0, R_RD02);
            6'd25: s = mk(1, 9, 1'b0, 1'b0, 1'b0, R_RD02);
            6'd26: s = mk(2, 10, 1'b0, 1'b0, 1'b1, R_RD02);
            6'd27: s = mk(0, 1, 1'b0, 1'b0, 1'b0, R_CD01);
            6'd28: s = mk(4, 5, 1'b0, 1'b0, 1'b0, R_CD01);
            6'd29: s = mk(8, 9, 1'b0, 1'b0, 1'b1, R_CD01);
            6'd30: s = mk(1, 2, 1'b0, 1'b0, 1'b0, R_CD12);
            6'd31: s = mk(5, 6, 1'b0, 1'b0, 1'b0, R_CD12);
            6'd32: s = mk(9, 10, 1'b0, 1'b0, 1'b1, R_CD12);
            6'd33: s = mk(0, 2, 1'b0, 1'b0, 1'b0, R_CD02);
            6'd34: s = mk(4, 6, 1'b0, 1'b0, 1'b0, R_CD02);
            6'd35: s = mk(8, 10, 1'b0, 1'b0, 1'b1, R_CD02);
            6'd36: s = mk(5, 10, 1'b0, 1'b0, 1'b0, R_C0);
            6'd37: s = mk(6, 9, 1'b0, 1'b1, 1'b1, R_C0);
            6'd38: s = mk(4, 10, 1'b0, 1'b0, 1'b0, R_C1);
            6'd39: s = mk(6, 8, 1'b0, 1'b1, 1'b1, R_C1);
            6'd40: s = mk(4, 9, 1'b0, 1'b0, 1'b0, R_C2);
            6'd41: s = mk(5, 8, 1'b0, 1'b1, 1'b1, R_C2);
            6'd42: s = mk(0, int'(R_C0), 1'b1, 1'b0, 1'b0, R_DET);
            6'd43: s = mk(1, int'(R_C1), 1'b1, 1'b1, 1'b0, R_DET);
            6'd44: s = mk(2, int'(R_C2), 1'b1, 1'b0, 1'b1, R_DET);
            default: s = mk(0, 0, 1'b0, 1'b0, 1'b0, R_RN0);
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mps_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`default_nettype none

module mps_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic      [WIDTH-1:0]         rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

// ===== rtl/mps_lane.sv =====
// One classifier lane: decodes 16 float elements to fixed point, runs the product
// schedule on a shared 32x32 multiplier and grades the matrix. Uses mps_pkg, mps_ram.
`default_nettype none

module mps_lane import mps_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter bit IS_DOUBLE     = 1'b0
) (
    input  wire logic                                         aclk,
    input  wire logic                                         aresetn,
    input  wire logic                                         start,
    input  wire logic [NUM_ELEMS*(IS_DOUBLE ? 64 : 32)-1:0]   raw_in,
    output lane_status_t                                      status
);

    localparam int EW     = IS_DOUBLE ? 64 : 32;
    localparam int EXP_W  = IS_DOUBLE ? 11 : 8;
    localparam int MAN_W  = IS_DOUBLE ? 52 : 23;
    localparam int BIAS   = IS_DOUBLE ? 1023 : 127;
    localparam int MAG_W  = FRACTION_BITS + 5;
    localparam int WIDE_W = MAN_W + MAG_W + 2;

    localparam logic [63:0] LIMIT = (64'd1 << MAG_W) - 64'd1;
    localparam logic signed [63:0] ONE    = signed'(64'd1 << FRACTION_BITS);
    localparam logic signed [63:0] TWENTY = signed'(64'd20 << FRACTION_BITS);
    localparam logic signed [63:0] T12 = signed'(((64'd12 << FRACTION_BITS) + 64'd50) / 64'd100);
    localparam logic signed [63:0] T20 = signed'(((64'd20 << FRACTION_BITS) + 64'd50) / 64'd100);
    localparam logic signed [63:0] T08 = signed'(((64'd8 << FRACTION_BITS) + 64'd50) / 64'd100);
    localparam logic signed [63:0] T05 = signed'(((64'd5 << FRACTION_BITS) + 64'd50) / 64'd100);
    localparam logic signed [63:0] T01 = signed'(((64'd1 << FRACTION_BITS) + 64'd50) / 64'd100);

    typedef struct packed {
        logic              fin;
        logic signed [63:0] val;
    } dec_t;

    typedef enum logic [2:0] {
        L_IDLE,
        L_LOAD,
        L_ADDR,
        L_OPER,
        L_MUL,
        L_ACC,
        L_EVAL
    } lstate_t;

    // Float to fixed point: truncate toward zero, saturate large magnitudes
    function automatic dec_t decode(input logic [EW-1:0] raw);
        dec_t               d;
        logic [EXP_W-1:0]   e;
        logic [MAN_W:0]     m;
        logic signed [13:0] s;
        logic [13:0]        sh;
        logic [WIDE_W-1:0]  wide;
        logic [63:0]        mag;
        e    = raw[EW-2 -: EXP_W];
        m    = {(e != '0), raw[MAN_W-1:0]};
        s    = (e == '0) ? 14'(1 - BIAS - MAN_W + FRACTION_BITS)
                         : 14'(e) - 14'(BIAS + MAN_W - FRACTION_BITS);
        sh   = 14'(-s);
        wide = '0;
        d.fin = 1'b1;
        if (&e) begin
            d.fin = 1'b0;
            mag   = LIMIT;
        end else if (m == '0) begin
            mag = '0;
        end else if (s >= 0) begin
            if (s > 14'(MAG_W)) begin
                mag = LIMIT;
            end else begin
                wide = WIDE_W'(m) << s[5:0];
                mag  = (wide > WIDE_W'(LIMIT)) ? LIMIT : 64'(wide);
            end
        end else begin
            mag = (sh > 14'(MAN_W)) ? 64'd0 : 64'(m >> sh[5:0]);
        end
        d.val = raw[EW-1] ? -signed'(mag) : signed'(mag);
        return d;
    endfunction

    function automatic logic signed [63:0] abs64(input logic signed [63:0] v);
        return v[63] ? -v : v;
    endfunction

    lstate_t            state_reg;
    logic [3:0]         cnt_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [EW*NUM_ELEMS-1:0] sh_reg;
    logic               fin_reg;
    logic signed [63:0] m0_reg, m5_reg, m11_reg, m14_reg, m15_reg;
    logic [63:0]        ua_reg, ub_reg;
    logic               neg_reg;
    logic [127:0]       prod_reg;
    logic signed [63:0] acc_reg;
    logic signed [63:0] res_reg [NUM_ELEMS];
    logic               done_reg;
    kind_t              kind_reg;

    step_t              cur;
    dec_t               dec;
    logic [63:0]        rdata_a, rdata_b;
    logic signed [63:0] a_val, b_val;
    logic [63:0]        a_mag, b_mag;
    logic [31:0]        op_x, op_y;
    logic [63:0]        partial;
    logic [6:0]         pshift;
    logic [127:0]       shifted;
    logic signed [63:0] r_val, acc_sum;
    kind_t              kind_eval;

    assign cur = step_rom(step_reg);
    assign dec = decode(sh_reg[EW-1:0]);

    // Element store, written during the decode sweep
    mps_ram #(
        .WIDTH (VAL_W),
        .DEPTH (NUM_ELEMS)
    ) u_elems (
        .aclk    (aclk),
        .we      (state_reg == L_LOAD),
        .waddr   (cnt_reg),
        .wdata   (dec.val),
        .raddr_a (cur.a),
        .rdata_a (rdata_a),
        .raddr_b (cur.b),
        .rdata_b (rdata_b)
    );

    // Operand selection and magnitudes
    always_comb begin
        a_val = signed'(rdata_a);
        if (cur.b_res) begin
            case (res_sel_t'(cur.b))
                R_C1:    b_val = res_reg[R_C1];
                R_C2:    b_val = res_reg[R_C2];
                default: b_val = res_reg[R_C0];
            endcase
        end else begin
            b_val = signed'(rdata_b);
        end
        a_mag = a_val[63] ? 64'(-a_val) : 64'(a_val);
        b_mag = b_val[63] ? 64'(-b_val) : 64'(b_val);
    end

    // One 32x32 partial product per cycle
    always_comb begin
        op_x    = ua_reg[32*cnt_reg[1] +: 32];
        op_y    = ub_reg[32*cnt_reg[0] +: 32];
        partial = 64'(op_x) * 64'(op_y);
        pshift  = {cnt_reg[1] & cnt_reg[0], cnt_reg[1] ^ cnt_reg[0], 5'b0};
        shifted = {64'b0, partial} << pshift;
        r_val   = signed'({1'b0, prod_reg[FRACTION_BITS +: 63]});
        acc_sum = acc_reg + (neg_reg ? -r_val : r_val);
    end

    // Grading from the finished schedule
    always_comb begin
        logic rows_ok, cols_ok, dots_ok, det_ok, m15_ok, view_ok;
        logic proj_a, proj_b, proj_ok;
        logic signed [63:0] d01, d12, d02;
        rows_ok = (abs64(res_reg[R_RN0] - ONE) < T12) && (abs64(res_reg[R_RN1] - ONE) < T12)
               && (abs64(res_reg[R_RN2] - ONE) < T12);
        cols_ok = (abs64(res_reg[R_CN0] - ONE) < T12) && (abs64(res_reg[R_CN1] - ONE) < T12)
               && (abs64(res_reg[R_CN2] - ONE) < T12);
        d01 = rows_ok ? res_reg[R_RD01] : res_reg[R_CD01];
        d12 = rows_ok ? res_reg[R_RD12] : res_reg[R_CD12];
        d02 = rows_ok ? res_reg[R_RD02] : res_reg[R_CD02];
        dots_ok = !(abs64(d01) > T12) && !(abs64(d12) > T12) && !(abs64(d02) > T12);
        det_ok  = !(abs64(abs64(res_reg[R_DET]) - ONE) > T20);
        m15_ok  = !(abs64(m15_reg - ONE) > T08);
        view_ok = (rows_ok || cols_ok) && dots_ok && det_ok && m15_ok;
        proj_a  = abs64(abs64(m11_reg) - ONE) <= T05;
        proj_b  = abs64(abs64(m14_reg) - ONE) <= T05;
        proj_ok = (abs64(m15_reg) <= T01) && (proj_a || proj_b)
               && (m0_reg > T05) && (m0_reg <= TWENTY)
               && (m5_reg > T05) && (m5_reg <= TWENTY);
        if (!fin_reg) begin
            kind_eval = K_NONE;
        end else if (view_ok) begin
            kind_eval = K_VIEW;
        end else if (proj_ok) begin
            kind_eval = K_PROJ;
        end else begin
            kind_eval = K_NONE;
        end
    end

    // Sequencer: decode sweep, then the address, operand, multiply and accumulate states per schedule step
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
            kind_reg  <= K_NONE;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                L_IDLE: begin
                    if (start) begin
                        sh_reg    <= raw_in;
                        cnt_reg   <= '0;
                        fin_reg   <= 1'b1;
                        acc_reg   <= '0;
                        state_reg <= L_LOAD;
                    end
                end
                L_LOAD: begin
                    sh_reg  <= sh_reg >> EW;
                    fin_reg <= fin_reg & dec.fin;
                    case (cnt_reg)
                        4'd0:    m0_reg  <= dec.val;
                        4'd5:    m5_reg  <= dec.val;
                        4'd11:   m11_reg <= dec.val;
                        4'd14:   m14_reg <= dec.val;
                        4'd15:   m15_reg <= dec.val;
                        default: ;
                    endcase
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'(NUM_ELEMS - 1)) begin
                        step_reg  <= '0;
                        state_reg <= L_ADDR;
                    end
                end
                L_ADDR: begin
                    state_reg <= L_OPER;
                end
                L_OPER: begin
                    ua_reg    <= a_mag;
                    ub_reg    <= b_mag;
                    // product sign, flipped again for subtracted steps
                    neg_reg   <= a_val[63] ^ b_val[63] ^ cur.neg;
                    prod_reg  <= '0;
                    cnt_reg   <= '0;
                    state_reg <= L_MUL;
                end
                L_MUL: begin
                    prod_reg <= prod_reg + shifted;
                    cnt_reg  <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd3) begin
                        state_reg <= L_ACC;
                    end
                end
                L_ACC: begin
                    if (cur.last) begin
                        res_reg[cur.dst] <= acc_sum;
                        acc_reg          <= '0;
                    end else begin
                        acc_reg <= acc_sum;
                    end
                    if (step_reg == STEP_W'(NUM_STEPS - 1)) begin
                        state_reg <= L_EVAL;
                    end else begin
                        step_reg  <= step_reg + STEP_W'(1);
                        state_reg <= L_ADDR;
                    end
                end
                L_EVAL: begin
                    kind_reg  <= kind_eval;
                    done_reg  <= 1'b1;
                    state_reg <= L_IDLE;
                end
                default: state_reg <= L_IDLE;
            endcase
        end
    end

    assign status.done = done_reg;
    assign status.kind = kind_reg;

endmodule

`default_nettype wire

// ===== rtl/mps_merge.sv =====
// Merge stage: orders the lane verdicts (double first), applies the candidate limit
// and drives the result output register. Uses mps_pkg.
`default_nettype none

module mps_merge import mps_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire merge_req_t        req,
    input  wire logic              clear_count,
    input  wire logic [CNT_W-1:0]  max_candidates,
    output logic                   done,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [IDX_W-1:0]       m_match_index,
    output logic                   m_is_double,
    output logic                   m_is_view,
    output logic                   m_is_last
);

    typedef enum logic [1:0] {
        M_IDLE,
        M_DBL,
        M_SGL
    } mstate_t;

    mstate_t           state_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              emit_d_reg, emit_s_reg, view_d_reg, view_s_reg;
    logic              done_reg;
    logic              valid_reg;
    logic [IDX_W-1:0]  index_reg;
    logic              double_reg, view_reg, last_reg;

    logic              emit_d, emit_s, out_free;
    logic [CNT_W:0]    cnt_plus;
    logic [CNT_W-1:0]  cnt_inc;

    // Limit check for both candidates, the second seeing the first one's count
    always_comb begin
        emit_d   = (req.kind_d != K_NONE) && (cnt_reg < max_candidates);
        cnt_plus = {1'b0, cnt_reg} + (CNT_W+1)'(emit_d);
        emit_s   = (req.kind_s != K_NONE) && (cnt_plus < {1'b0, max_candidates});
        out_free = !valid_reg || m_ready;
        cnt_inc  = (cnt_reg != '1) ? cnt_reg + CNT_W'(1) : cnt_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (m_ready) begin
                valid_reg <= 1'b0;
            end
            if (clear_count) begin
                cnt_reg <= '0;
            end
            unique case (state_reg)
                M_IDLE: begin
                    if (req.start) begin
                        idx_reg    <= req.idx;
                        emit_d_reg <= emit_d;
                        emit_s_reg <= emit_s;
                        view_d_reg <= (req.kind_d == K_VIEW);
                        view_s_reg <= (req.kind_s == K_VIEW);
                        state_reg  <= M_DBL;
                    end
                end
                M_DBL: begin
                    if (!emit_d_reg) begin
                        state_reg <= M_SGL;
                    end else if (out_free) begin
                        valid_reg  <= 1'b1;
                        index_reg  <= idx_reg - IDX_W'(7);
                        double_reg <= 1'b1;
                        view_reg   <= view_d_reg;
                        last_reg   <= !emit_s_reg;
                        cnt_reg    <= cnt_inc;
                        state_reg  <= M_SGL;
                    end
                end
                M_SGL: begin
                    if (!emit_s_reg) begin
                        done_reg  <= 1'b1;
                        state_reg <= M_IDLE;
                    end else if (out_free) begin
                        valid_reg  <= 1'b1;
                        index_reg  <= idx_reg - IDX_W'(3);
                        double_reg <= 1'b0;
                        view_reg   <= view_s_reg;
                        last_reg   <= 1'b1;
                        cnt_reg    <= cnt_inc;
                        done_reg   <= 1'b1;
                        state_reg  <= M_IDLE;
                    end
                end
                default: state_reg <= M_IDLE;
            endcase
        end
    end

    assign done          = done_reg;
    assign m_valid       = valid_reg;
    assign m_match_index = index_reg;
    assign m_is_double   = double_reg;
    assign m_is_view     = view_reg;
    assign m_is_last     = last_reg;

endmodule

`default_nettype wire

// ===== rtl/matrix_pattern_memory_scanner.sv =====
// Top level of the matrix pattern scanner: chunk window, config register, two
// classifier lanes (double, single) and the merge stage. Uses mps_pkg, mps_lane, mps_merge.
//
//  channel  direction  handshake            payload
//  s_       in         s_valid / s_ready    chunk_low, chunk_high, chunk_index,
//                                           block_start, sweep_start
//  m_       out        m_valid / m_ready    match_index, is_double, is_view, is_last
//  cfg_     in         cfg_valid/cfg_ready  max_candidates
//
// For one chunk each lane decodes its 16 elements, then computes 45 products of the
// matrix tests on its one 32x32 multiplier (four partial products each) and grades
// the matrix; the merge stage then passes the verdicts to the output.
// Both lanes run in lockstep; a chunk is taken only while the block is idle.
// A stalled output holds the merge stage; cfg_ready is always high.
// Reset is synchronous, active low; the window contents are not cleared.
`default_nettype none

module matrix_pattern_memory_scanner import mps_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [63:0]       s_chunk_low,
    input  wire logic [63:0]       s_chunk_high,
    input  wire logic [IDX_W-1:0]  s_chunk_index,
    input  wire logic              s_block_start,
    input  wire logic              s_sweep_start,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [IDX_W-1:0]       m_match_index,
    output logic                   m_is_double,
    output logic                   m_is_view,
    output logic                   m_is_last,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CNT_W-1:0]  cfg_max_candidates
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_MERGE
    } tstate_t;

    tstate_t              state_reg;
    logic [CHUNK_W-1:0]   win_reg [WIN_DEPTH];
    logic [FILL_W-1:0]    fill_reg;
    logic [CNT_W-1:0]     max_reg;
    logic                 en_d_reg, en_s_reg;
    logic [IDX_W-1:0]     idx_reg;

    logic [CHUNK_W-1:0]   win_next [WIN_DEPTH];
    logic [FILL_W-1:0]    fill_base, fill_next;
    logic [NUM_ELEMS*64-1:0] raw_d;
    logic [NUM_ELEMS*32-1:0] raw_s;
    logic                 accept;
    lane_status_t         stat_d, stat_s;
    merge_req_t           mreq;
    logic                 merge_done;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // Window after this chunk, newest entry last
    always_comb begin
        for (int i = 0; i < WIN_DEPTH - 1; i++) begin
            win_next[i] = win_reg[i+1];
        end
        win_next[WIN_DEPTH-1] = {s_chunk_high, s_chunk_low};
        for (int i = 0; i < WIN_DEPTH; i++) begin
            raw_d[CHUNK_W*i +: CHUNK_W] = win_next[i];
        end
        for (int i = 0; i < WIN_DEPTH / 2; i++) begin
            raw_s[CHUNK_W*i +: CHUNK_W] = win_next[WIN_DEPTH/2 + i];
        end
        fill_base = s_block_start ? '0 : fill_reg;
        fill_next = (fill_base < FILL_W'(WIN_DEPTH)) ? fill_base + FILL_W'(1) : fill_base;
    end

    // Lanes: double matrix over 128 bytes, single matrix over the newest 64 bytes
    mps_lane #(
        .FRACTION_BITS (FRACTION_BITS),
        .IS_DOUBLE     (1'b1)
    ) u_lane_d (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .raw_in  (raw_d),
        .status  (stat_d)
    );

    mps_lane #(
        .FRACTION_BITS (FRACTION_BITS),
        .IS_DOUBLE     (1'b0)
    ) u_lane_s (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .raw_in  (raw_s),
        .status  (stat_s)
    );

    // Verdicts of lanes whose window was full enough; the double lane also needs an odd chunk index
    always_comb begin
        mreq.start  = (state_reg == ST_RUN) && stat_d.done && stat_s.done;
        mreq.idx    = idx_reg;
        mreq.kind_d = en_d_reg ? stat_d.kind : K_NONE;
        mreq.kind_s = en_s_reg ? stat_s.kind : K_NONE;
    end

    mps_merge u_merge (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .req            (mreq),
        .clear_count    (accept && s_sweep_start),
        .max_candidates (max_reg),
        .done           (merge_done),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_match_index  (m_match_index),
        .m_is_double    (m_is_double),
        .m_is_view      (m_is_view),
        .m_is_last      (m_is_last)
    );

    // Control, window and config register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            max_reg   <= MAX_CAND_RST;
        end else begin
            if (cfg_valid) begin
                max_reg <= cfg_max_candidates;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        win_reg   <= win_next;
                        fill_reg  <= fill_next;
                        idx_reg   <= s_chunk_index;
                        en_d_reg  <= (fill_next >= FILL_W'(WIN_DEPTH)) && s_chunk_index[0];
                        en_s_reg  <= (fill_next >= FILL_W'(WIN_DEPTH / 2));
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (mreq.start) begin
                        state_reg <= ST_MERGE;
                    end
                end
                ST_MERGE: begin
                    if (merge_done) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Lanes run the same schedule and must finish together
    a_lanes_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        stat_d.done == stat_s.done)
        else $error("lane completion out of step");

    // Window fill never passes the window depth
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(WIN_DEPTH))
        else $error("window fill overflow");

    // A new result appears only while the merge stage owns the chunk
    a_result_in_merge: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_MERGE))
        else $error("result outside merge phase");

    // No chunk is taken while lanes are busy
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |=> !(stat_d.done && $past(accept)))
        else $error("chunk accepted during lane run");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for matrix_pattern_memory_scanner: chunk streams carry float and
// double view/projection matrices plus noise, checked against a fixed-point predictor.
// Depends on rtl/mps_pkg.sv and the block's RTL.
`default_nettype none

module tb_top;
    import mps_pkg::*;

    localparam int     FB         = FRACTION_BITS_DEF;
    localparam longint FX_ONE     = longint'(1) <<< FB;
    localparam longint FX_TWENTY  = longint'(20) <<< FB;
    localparam longint FX_SAT     = (longint'(32) <<< FB) - 1;
    localparam int     SETTLE     = 400;
    localparam int     WDOG_LIMIT = 5000;

    typedef struct {
        logic [IDX_W-1:0] idx;
        logic             dbl;
        logic             view;
        logic             last;
    } match_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [63:0]          s_chunk_low = '0;
    logic [63:0]          s_chunk_high = '0;
    logic [IDX_W-1:0]     s_chunk_index = '0;
    logic                 s_block_start = 1'b0;
    logic                 s_sweep_start = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [IDX_W-1:0]     m_match_index;
    logic                 m_is_double;
    logic                 m_is_view;
    logic                 m_is_last;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CNT_W-1:0]     cfg_max_candidates = '0;

    // predictor state
    logic [63:0]          win_lo [WIN_DEPTH];
    logic [63:0]          win_hi [WIN_DEPTH];
    int                   win_fill = 0;
    int                   cand_count = 0;
    int                   cand_limit = 512;
    match_t               pending_matches [$];

    // stimulus state
    int                   err_count = 0;
    int                   snd_idle_pct = 0;
    int                   rcv_stall_pct = 0;
    int                   chunks_sent = 0;
    int                   wdog = 0;
    logic [IDX_W-1:0]     next_idx = '0;
    real                  mat [16];

    matrix_pattern_memory_scanner dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_chunk_low(s_chunk_low), .s_chunk_high(s_chunk_high),
        .s_chunk_index(s_chunk_index), .s_block_start(s_block_start),
        .s_sweep_start(s_sweep_start),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_match_index(m_match_index), .m_is_double(m_is_double),
        .m_is_view(m_is_view), .m_is_last(m_is_last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_max_candidates(cfg_max_candidates)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ---------------- fixed-point predictor ----------------

    function automatic longint fx_abs(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint hund(int n);
        return ((longint'(n) <<< FB) + 50) / 100;
    endfunction

    // product truncated toward zero
    function automatic longint fx_mul(longint a, longint b);
        logic          neg;
        logic [63:0]   ua;
        logic [63:0]   ub;
        logic [127:0]  p;
        logic [63:0]   r;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        p = {64'b0, ua} * {64'b0, ub};
        r = p[FB+63:FB];
        r[63] = 1'b0;
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint fx_scale(logic neg, logic [63:0] m, int s);
        logic [63:0] r;
        if (m == 0) return 0;
        if (s >= 0) begin
            if (s >= 63 || m > (64'(FX_SAT) >> s)) r = 64'(FX_SAT);
            else r = m << s;
        end else begin
            r = (-s >= 64) ? 64'd0 : (m >> (-s));
        end
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint dec32(logic [31:0] b, inout logic fin);
        int e;
        e = int'(b[30:23]);
        if (e == 255) begin
            fin = 1'b0;
            return b[31] ? -FX_SAT : FX_SAT;
        end
        if (e == 0) return fx_scale(b[31], {41'b0, b[22:0]}, 1 - 150 + FB);
        return fx_scale(b[31], {40'b0, 1'b1, b[22:0]}, e - 150 + FB);
    endfunction

    function automatic longint dec64(logic [63:0] b, inout logic fin);
        int e;
        e = int'(b[62:52]);
        if (e == 2047) begin
            fin = 1'b0;
            return b[63] ? -FX_SAT : FX_SAT;
        end
        if (e == 0) return fx_scale(b[63], {12'b0, b[51:0]}, 1 - 1075 + FB);
        return fx_scale(b[63], {11'b0, 1'b1, b[51:0]}, e - 1075 + FB);
    endfunction

    function automatic longint dot3(longint m [16], int a, int b, int st);
        return fx_mul(m[a], m[b]) + fx_mul(m[a+st], m[b+st])
             + fx_mul(m[a+2*st], m[b+2*st]);
    endfunction

    function automatic logic near_one(longint v, longint tol);
        return fx_abs(v - FX_ONE) < tol;
    endfunction

    function automatic logic view_ok(longint m [16]);
        longint t;
        logic   rows;
        logic   cols;
        longint d01;
        longint d12;
        longint d02;
        longint det;
        t = hund(12);
        rows = near_one(dot3(m, 0, 0, 1), t) && near_one(dot3(m, 4, 4, 1), t)
            && near_one(dot3(m, 8, 8, 1), t);
        cols = near_one(dot3(m, 0, 0, 4), t) && near_one(dot3(m, 1, 1, 4), t)
            && near_one(dot3(m, 2, 2, 4), t);
        if (!rows && !cols) return 1'b0;
        if (rows) begin
            d01 = dot3(m, 0, 4, 1); d12 = dot3(m, 4, 8, 1); d02 = dot3(m, 0, 8, 1);
        end else begin
            d01 = dot3(m, 0, 1, 4); d12 = dot3(m, 1, 2, 4); d02 = dot3(m, 0, 2, 4);
        end
        if (fx_abs(d01) > t || fx_abs(d12) > t || fx_abs(d02) > t) return 1'b0;
        det = fx_mul(m[0], fx_mul(m[5], m[10]) - fx_mul(m[6], m[9]))
            - fx_mul(m[1], fx_mul(m[4], m[10]) - fx_mul(m[6], m[8]))
            + fx_mul(m[2], fx_mul(m[4], m[9]) - fx_mul(m[5], m[8]));
        if (fx_abs(fx_abs(det) - FX_ONE) > hund(20)) return 1'b0;
        if (fx_abs(m[15] - FX_ONE) > hund(8)) return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic proj_ok(longint m [16]);
        logic a;
        logic b;
        a = fx_abs(fx_abs(m[11]) - FX_ONE) <= hund(5);
        b = fx_abs(fx_abs(m[14]) - FX_ONE) <= hund(5);
        if (fx_abs(m[15]) > hund(1) || (!a && !b)) return 1'b0;
        if (m[0] <= hund(5) || m[0] > FX_TWENTY) return 1'b0;
        if (m[5] <= hund(5) || m[5] > FX_TWENTY) return 1'b0;
        return 1'b1;
    endfunction

    function automatic kind_t grade(longint m [16], logic fin);
        if (!fin) return K_NONE;
        if (view_ok(m)) return K_VIEW;
        return proj_ok(m) ? K_PROJ : K_NONE;
    endfunction

    function automatic void add_match(logic [IDX_W-1:0] idx, logic dbl, kind_t k,
                                      inout int n);
        match_t r;
        if (k == K_NONE || cand_count >= cand_limit) return;
        r.idx = idx;
        r.dbl = dbl;
        r.view = (k == K_VIEW);
        r.last = 1'b0;
        pending_matches = {pending_matches, r};
        if (cand_count < 8191) cand_count++;
        n++;
    endfunction

    // window update and both matrix tests for one accepted chunk
    function automatic void scan_chunk(logic [63:0] lo, logic [63:0] hi,
                                       logic [IDX_W-1:0] idx, logic bs, logic ss);
        longint      m [16];
        logic        fin;
        logic [63:0] w;
        int          n;
        n = 0;
        if (bs) win_fill = 0;
        if (ss) cand_count = 0;
        for (int i = 0; i < WIN_DEPTH - 1; i++) begin
            win_lo[i] = win_lo[i+1];
            win_hi[i] = win_hi[i+1];
        end
        win_lo[7] = lo;
        win_hi[7] = hi;
        if (win_fill < 8) win_fill++;
        if (win_fill >= 8 && idx[0]) begin
            fin = 1'b1;
            for (int k = 0; k < 16; k++)
                m[k] = dec64(k[0] ? win_hi[k>>1] : win_lo[k>>1], fin);
            add_match(idx - IDX_W'(7), 1'b1, grade(m, fin), n);
        end
        if (win_fill >= 4) begin
            fin = 1'b1;
            for (int k = 0; k < 16; k++) begin
                w = k[1] ? win_hi[4 + (k>>2)] : win_lo[4 + (k>>2)];
                m[k] = dec32(k[0] ? w[63:32] : w[31:0], fin);
            end
            add_match(idx - IDX_W'(3), 1'b0, grade(m, fin), n);
        end
        if (n > 0) pending_matches[$].last = 1'b1;
    endfunction

    // ---------------- monitors ----------------

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            scan_chunk(s_chunk_low, s_chunk_high, s_chunk_index, s_block_start,
                       s_sweep_start);
        if (aresetn && cfg_valid && cfg_ready)
            cand_limit = int'(cfg_max_candidates);
    end

    // compare each result transaction with the oldest expected match
    always @(posedge aclk) begin
        match_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_matches.size() == 0) begin
                $error("unexpected match: index %h double %b view %b", m_match_index,
                       m_is_double, m_is_view);
                err_count++;
            end else begin
                e = pending_matches.pop_front();
                if (m_match_index !== e.idx) begin
                    $error("match_index: expected %h, got %h", e.idx, m_match_index);
                    err_count++;
                end
                if (m_is_double !== e.dbl) begin
                    $error("is_double: expected %b, got %b", e.dbl, m_is_double);
                    err_count++;
                end
                if (m_is_view !== e.view) begin
                    $error("is_view: expected %b, got %b", e.view, m_is_view);
                    err_count++;
                end
                if (m_is_last !== e.last) begin
                    $error("is_last: expected %b, got %b", e.last, m_is_last);
                    err_count++;
                end
            end
        end
    end

    // receiver back-pressure
    always @(negedge aclk)
        m_ready <= ($urandom_range(99) >= rcv_stall_pct);

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ---------------- stimulus helpers ----------------

    function automatic logic [31:0] to_f32(real r);
        logic [63:0] d;
        int          e;
        d = $realtobits(r);
        e = int'(d[62:52]) - 1023 + 127;
        if (d[62:52] == 0 || e <= 0) return {d[63], 31'b0};
        if (e >= 255) return {d[63], 8'hff, 23'b0};
        return {d[63], 8'(e), d[51:29]};
    endfunction

    function automatic real rnd(int lo_milli, int hi_milli);
        return real'($urandom_range(hi_milli - lo_milli)) / 1000.0 + real'(lo_milli) / 1000.0;
    endfunction

    // send one chunk; valid stays high into the next call unless the sender idles
    task automatic send_chunk(logic [63:0] lo, logic [63:0] hi, logic bs, logic ss);
        if ($urandom_range(99) < snd_idle_pct) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_chunk_low = lo;
        s_chunk_high = hi;
        s_chunk_index = next_idx;
        s_block_start = bs;
        s_sweep_start = ss;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        next_idx = next_idx + 1'b1;
        chunks_sent++;
    endtask

    task automatic send_noise(logic bs, logic ss);
        logic [63:0] lo;
        logic [63:0] hi;
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
        // special exponents now and then
        case ($urandom_range(7))
            0: lo[30:23] = 8'hff;
            1: hi[62:52] = 11'h7ff;
            2: lo[62:55] = 8'h00;
            default: ;
        endcase
        send_chunk(lo, hi, bs, ss);
    endtask

    task automatic send_single(logic bs, logic ss);
        for (int j = 0; j < 4; j++)
            send_chunk({to_f32(mat[4*j+1]), to_f32(mat[4*j])},
                       {to_f32(mat[4*j+3]), to_f32(mat[4*j+2])},
                       (j == 0) ? bs : 1'b0, (j == 0) ? ss : 1'b0);
    endtask

    // a double matrix must start at an even chunk index
    task automatic send_double(logic bs, logic ss);
        if (next_idx[0]) send_noise(1'b0, 1'b0);
        for (int j = 0; j < 8; j++)
            send_chunk($realtobits(mat[2*j]), $realtobits(mat[2*j+1]),
                       (j == 0) ? bs : 1'b0, (j == 0) ? ss : 1'b0);
    endtask

    task automatic make_identity();
        foreach (mat[k]) mat[k] = (k % 5 == 0) ? 1.0 : 0.0;
    endtask

    task automatic make_view();
        real ca, sa, cb, sb, a, b;
        a = rnd(0, 6283);
        b = rnd(0, 6283);
        ca = $cos(a); sa = $sin(a); cb = $cos(b); sb = $sin(b);
        mat[0] = ca;  mat[1] = -sa * cb; mat[2]  = sa * sb;  mat[3]  = 0.0;
        mat[4] = sa;  mat[5] = ca * cb;  mat[6]  = -ca * sb; mat[7]  = 0.0;
        mat[8] = 0.0; mat[9] = sb;       mat[10] = cb;       mat[11] = 0.0;
        mat[12] = rnd(-40000, 40000); mat[13] = rnd(-40000, 40000);
        mat[14] = rnd(-40000, 40000); mat[15] = 1.0;
        if ($urandom_range(1)) begin
            // transposed rotation: column normalized layout
            for (int r = 0; r < 3; r++)
                for (int c = r + 1; c < 3; c++) begin
                    a = mat[4*r+c]; mat[4*r+c] = mat[4*c+r]; mat[4*c+r] = a;
                end
        end
    endtask

    task automatic make_proj();
        real f, asp;
        foreach (mat[k]) mat[k] = 0.0;
        f = rnd(20, 24000);
        asp = rnd(500, 2000);
        mat[0] = f / asp;
        mat[5] = f;
        mat[10] = -rnd(1000, 1100);
        if ($urandom_range(1)) mat[11] = -1.0; else mat[14] = -1.0;
        mat[15] = 0.0;
        if ($urandom_range(3) == 0) mat[11] = -mat[11];
    endtask

    // push one element off to land near the thresholds
    task automatic perturb();
        int k;
        k = $urandom_range(15);
        case ($urandom_range(2))
            0: mat[k] = mat[k] * rnd(700, 1300);
            1: mat[k] = mat[k] + rnd(-150, 150);
            default: ;
        endcase
    endtask

    task automatic wait_drain();
        s_valid = 1'b0;
        while (pending_matches.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_limit(int v);
        wait_drain();
        cfg_max_candidates = CNT_W'(v);
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // ---------------- tests ----------------

    task automatic test_directed_matrices();
        make_identity();
        send_single(1'b1, 1'b1);
        send_double(1'b1, 1'b0);
        make_proj();
        mat[0] = 20.0; mat[5] = 0.0501; mat[11] = -1.05;
        send_single(1'b0, 1'b0);
        make_proj();
        send_double(1'b1, 1'b0);
        // non-finite elements fail both tests
        make_identity();
        mat[3] = 1.0e39;
        send_single(1'b1, 1'b0);
        send_chunk(64'h7ff8_0000_0000_0000, 64'h0, 1'b0, 1'b0);
        // subnormal, negative zero and largest magnitudes
        send_chunk(64'h8000_0000_0000_0001, 64'h7f7f_ffff_ff7f_ffff, 1'b0, 1'b0);
        send_chunk(64'h000f_ffff_ffff_ffff, 64'hffef_ffff_ffff_ffff, 1'b0, 1'b0);
    endtask

    task automatic test_short_window_and_wrap();
        make_identity();
        // block restart in the middle of a matrix
        send_chunk({to_f32(0.0), to_f32(1.0)}, 64'h0, 1'b1, 1'b0);
        send_chunk({to_f32(1.0), to_f32(0.0)}, 64'h0, 1'b0, 1'b0);
        send_single(1'b1, 1'b0);
        // match index wraps below zero after a jump near the top
        next_idx = IDX_W'(2);
        send_single(1'b1, 1'b0);
        next_idx = {IDX_W{1'b1}} - IDX_W'(1);
        send_double(1'b1, 1'b0);
    endtask

    task automatic test_candidate_limit();
        write_limit(0);
        make_identity();
        send_single(1'b1, 1'b1);
        send_double(1'b0, 1'b1);
        write_limit(3);
        send_double(1'b1, 1'b1);
        send_single(1'b0, 1'b0);
        send_single(1'b0, 1'b0);
        send_single(1'b0, 1'b1);
    endtask

    task automatic test_random_stream(int target, int limit_val, int snd, int rcv);
        int   goal;
        logic bs;
        logic ss;
        write_limit(limit_val);
        snd_idle_pct = snd;
        rcv_stall_pct = rcv;
        goal = chunks_sent + target;
        while (chunks_sent < goal) begin
            bs = ($urandom_range(9) == 0);
            ss = ($urandom_range(19) == 0);
            if ($urandom_range(49) == 0) next_idx = IDX_W'({$urandom, $urandom});
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5, 6, 7: begin
                    make_view();
                    if ($urandom_range(1)) perturb();
                    send_single(bs, ss);
                end
                8, 9, 10, 11: begin
                    make_proj();
                    if ($urandom_range(1)) perturb();
                    send_single(bs, ss);
                end
                12, 13, 14: begin
                    make_view();
                    if ($urandom_range(1)) perturb();
                    send_double(bs, ss);
                end
                15, 16: begin
                    make_proj();
                    if ($urandom_range(1)) perturb();
                    send_double(bs, ss);
                end
                default: begin
                    repeat ($urandom_range(1, 4)) send_noise(bs, ss);
                end
            endcase
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_directed_matrices();
        test_short_window_and_wrap();
        test_candidate_limit();
        test_random_stream(375, 4096, 0, 0);
        test_random_stream(375, 20, 83, 0);
        test_random_stream(375, 512, 0, 83);
        test_random_stream(375, 1, 27, 27);
        wait_drain();
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== matrix_pattern_memory_scanner.f =====
rtl/mps_pkg.sv
rtl/mps_ram.sv
rtl/mps_lane.sv
rtl/mps_merge.sv
rtl/matrix_pattern_memory_scanner.sv
tb/tb_top.sv
